// File: hdl/assert_macros.svh
// Assertion macros used by the RTL.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dcld_pkg.sv
// Package for the drive command line decoder: sizes, keyword codes,
// parse phases and command kinds. No dependencies.
package dcld_pkg;

  localparam int LINE_CHARS = 63;
  localparam int KEYWORD_CHARS = 15;
  localparam int LC_W = $clog2(LINE_CHARS + 1);
  localparam int KL_W = $clog2(KEYWORD_CHARS + 1);

  localparam int NUM_W = 15;
  localparam int VAL_W = NUM_W + 1;
  localparam int VEL_W = VAL_W + 1;
  localparam logic [NUM_W-1:0] NUM_LIMIT = 15'h7FFF;

  localparam logic [31:0] KW_FWD  = 32'h0046_5744;
  localparam logic [31:0] KW_BWD  = 32'h0042_5744;
  localparam logic [31:0] KW_TL   = 32'h0000_544C;
  localparam logic [31:0] KW_TR   = 32'h0000_5452;
  localparam logic [31:0] KW_STOP = 32'h5354_4F50;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_PRE_KW   = 3'd0,
    PH_KW       = 3'd1,
    PH_PRE_SPD  = 3'd2,
    PH_SPD_SIGN = 3'd3,
    PH_SPD_DIG  = 3'd4,
    PH_PRE_TRN  = 3'd5,
    PH_TRN      = 3'd6,
    PH_DONE     = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    CMD_FWD  = 3'd0,
    CMD_BWD  = 3'd1,
    CMD_TL   = 3'd2,
    CMD_TR   = 3'd3,
    CMD_HALT = 3'd4,
    CMD_UNK  = 3'd5
  } cmd_t;

endpackage

// File: hdl/drive_command_line_decoder_unit.sv
// Drive command line decoder: one byte per cycle into line parse state,
// one result per non-empty line. Depends on dcld_pkg and assert_macros.svh.
// Latency: the result is valid the cycle after its CR/LF request is accepted.
// Throughput: one byte per cycle; the output register stalls input only
// while a result waits and out_ready is low.
// Reset: synchronous rst_n clears parse state and the output valid.
`include "assert_macros.svh"

module drive_command_line_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_command_kind,
  output logic signed [16:0] out_left_vel,
  output logic signed [16:0] out_right_vel,
  output logic        out_moving_forward
);

  localparam int NW = dcld_pkg::NUM_W;
  localparam int VW = dcld_pkg::VAL_W;
  localparam int EW = dcld_pkg::VEL_W;

  logic [dcld_pkg::LC_W-1:0] cnt_r, cnt_nxt;
  dcld_pkg::phase_t          ph_r, ph_nxt;
  logic [31:0]               kw_r, kw_nxt;
  logic [dcld_pkg::KL_W-1:0] kwlen_r, kwlen_nxt;
  logic [NW-1:0]             acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [VW-1:0]      spd_r, spd_nxt;
  logic signed [VW-1:0]      trn_r, trn_nxt;

  logic                      out_valid_r, out_valid_nxt;
  dcld_pkg::cmd_t            kind_r, kind_nxt;
  logic signed [EW-1:0]      left_r, left_nxt;
  logic signed [EW-1:0]      right_r, right_nxt;
  logic                      fwd_r, fwd_nxt;

  logic                      accept, is_eol, emit, keep;
  logic                      ws, dig, sgn, go;
  logic [7:0]                c;
  logic [NW-1:0]             dval;
  logic [NW+3:0]             acc_mul;
  logic [NW-1:0]             acc_sat;
  logic signed [VW-1:0]      take_val;
  logic signed [VW-1:0]      v, t;

  assign c        = in_rx_byte;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_eol   = (c == dcld_pkg::CH_CR) || (c == dcld_pkg::CH_LF);
  assign emit     = accept && is_eol && (cnt_r != '0);
  assign keep     = accept && !is_eol && (cnt_r < dcld_pkg::LC_W'(dcld_pkg::LINE_CHARS));

  assign ws  = (c == dcld_pkg::CH_SP) || (c == dcld_pkg::CH_TAB) ||
               (c == dcld_pkg::CH_VT) || (c == dcld_pkg::CH_FF);
  assign dig = (c >= dcld_pkg::CH_ZERO) && (c <= dcld_pkg::CH_NINE);
  assign sgn = (c == dcld_pkg::CH_PLUS) || (c == dcld_pkg::CH_MINUS);

  assign dval     = NW'(c[3:0]);
  assign acc_mul  = (NW+4)'(acc_r) * (NW+4)'(10) + (NW+4)'(dval);
  assign acc_sat  = (acc_mul > (NW+4)'(dcld_pkg::NUM_LIMIT)) ? dcld_pkg::NUM_LIMIT
                                                              : acc_mul[NW-1:0];
  assign take_val = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});

  // per-byte parse step
  always_comb begin
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    kw_nxt    = kw_r;
    kwlen_nxt = kwlen_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    spd_nxt   = spd_r;
    trn_nxt   = trn_r;
    go        = 1'b1;
    if (emit) begin
      cnt_nxt   = '0;
      ph_nxt    = dcld_pkg::PH_PRE_KW;
      kw_nxt    = '0;
      kwlen_nxt = '0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      spd_nxt   = '0;
      trn_nxt   = '0;
    end else if (keep) begin
      cnt_nxt = cnt_r + 1'b1;
      if (c == dcld_pkg::CH_NUL) begin
        if (ph_r == dcld_pkg::PH_SPD_SIGN || ph_r == dcld_pkg::PH_SPD_DIG) begin
          spd_nxt = take_val;
          acc_nxt = '0;
          neg_nxt = 1'b0;
        end else if (ph_r == dcld_pkg::PH_TRN) begin
          trn_nxt = take_val;
          acc_nxt = '0;
          neg_nxt = 1'b0;
        end
        ph_nxt = dcld_pkg::PH_DONE;
      end else begin
        if (ph_nxt == dcld_pkg::PH_PRE_KW) begin
          if (ws) go = 1'b0;
          else ph_nxt = dcld_pkg::PH_KW;
        end
        if (go && ph_nxt == dcld_pkg::PH_KW) begin
          if (ws) begin
            ph_nxt = dcld_pkg::PH_PRE_SPD;
            go = 1'b0;
          end else if (kwlen_r < dcld_pkg::KL_W'(dcld_pkg::KEYWORD_CHARS)) begin
            if (kwlen_r < dcld_pkg::KL_W'(4)) kw_nxt = {kw_r[23:0], c};
            kwlen_nxt = kwlen_r + 1'b1;
            go = 1'b0;
          end else begin
            ph_nxt = dcld_pkg::PH_PRE_SPD;
          end
        end
        if (go && ph_nxt == dcld_pkg::PH_PRE_SPD) begin
          go = 1'b0;
          if (ws) begin
            ph_nxt = dcld_pkg::PH_PRE_SPD;
          end else if (sgn) begin
            neg_nxt = (c == dcld_pkg::CH_MINUS);
            ph_nxt  = dcld_pkg::PH_SPD_SIGN;
          end else if (dig) begin
            acc_nxt = dval;
            ph_nxt  = dcld_pkg::PH_SPD_DIG;
          end else begin
            ph_nxt = dcld_pkg::PH_DONE;
          end
        end
        if (go && ph_nxt == dcld_pkg::PH_SPD_SIGN) begin
          go = 1'b0;
          if (dig) begin
            acc_nxt = dval;
            ph_nxt  = dcld_pkg::PH_SPD_DIG;
          end else begin
            neg_nxt = 1'b0;
            ph_nxt  = dcld_pkg::PH_DONE;
          end
        end
        if (go && ph_nxt == dcld_pkg::PH_SPD_DIG) begin
          if (dig) begin
            acc_nxt = acc_sat;
            go = 1'b0;
          end else begin
            spd_nxt = take_val;
            acc_nxt = '0;
            neg_nxt = 1'b0;
            ph_nxt  = dcld_pkg::PH_PRE_TRN;
            if (ws) go = 1'b0;
          end
        end
        if (go && ph_nxt == dcld_pkg::PH_PRE_TRN) begin
          go = 1'b0;
          if (ws) begin
            ph_nxt = dcld_pkg::PH_PRE_TRN;
          end else if (sgn) begin
            neg_nxt = (c == dcld_pkg::CH_MINUS);
            ph_nxt  = dcld_pkg::PH_TRN;
          end else if (dig) begin
            acc_nxt = dval;
            ph_nxt  = dcld_pkg::PH_TRN;
          end else begin
            ph_nxt = dcld_pkg::PH_DONE;
          end
        end
        if (go && ph_nxt == dcld_pkg::PH_TRN) begin
          if (dig) begin
            acc_nxt = acc_sat;
          end else begin
            trn_nxt = take_val;
            acc_nxt = '0;
            neg_nxt = 1'b0;
            ph_nxt  = dcld_pkg::PH_DONE;
          end
        end
      end
    end
  end

  // line-end decode
  always_comb begin
    v = (ph_r == dcld_pkg::PH_SPD_DIG) ? take_val : spd_r;
    t = (ph_r == dcld_pkg::PH_TRN)     ? take_val : trn_r;
    kind_nxt  = dcld_pkg::CMD_UNK;
    left_nxt  = '0;
    right_nxt = '0;
    if (kwlen_r == dcld_pkg::KL_W'(3) && kw_r == dcld_pkg::KW_FWD) begin
      kind_nxt  = dcld_pkg::CMD_FWD;
      left_nxt  = EW'(v);
      right_nxt = EW'(v);
    end else if (kwlen_r == dcld_pkg::KL_W'(3) && kw_r == dcld_pkg::KW_BWD) begin
      kind_nxt  = dcld_pkg::CMD_BWD;
      left_nxt  = -EW'(v);
      right_nxt = -EW'(v);
    end else if (kwlen_r == dcld_pkg::KL_W'(2) && kw_r == dcld_pkg::KW_TL) begin
      kind_nxt  = dcld_pkg::CMD_TL;
      left_nxt  = EW'(v) + EW'(t);
      right_nxt = EW'(v) - EW'(t);
    end else if (kwlen_r == dcld_pkg::KL_W'(2) && kw_r == dcld_pkg::KW_TR) begin
      kind_nxt  = dcld_pkg::CMD_TR;
      left_nxt  = EW'(v) - EW'(t);
      right_nxt = EW'(v) + EW'(t);
    end else if (kwlen_r == dcld_pkg::KL_W'(4) && kw_r == dcld_pkg::KW_STOP) begin
      kind_nxt = dcld_pkg::CMD_HALT;
    end
    fwd_nxt = (left_nxt > 0) && (right_nxt > 0);
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ph_r        <= dcld_pkg::PH_PRE_KW;
      kw_r        <= '0;
      kwlen_r     <= '0;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      spd_r       <= '0;
      trn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ph_r        <= ph_nxt;
      kw_r        <= kw_nxt;
      kwlen_r     <= kwlen_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      spd_r       <= spd_nxt;
      trn_r       <= trn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r  <= kind_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      fwd_r   <= fwd_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_command_kind   = kind_r;
  assign out_left_vel       = left_r;
  assign out_right_vel      = right_r;
  assign out_moving_forward = fwd_r;

  `ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= dcld_pkg::LC_W'(dcld_pkg::LINE_CHARS),
              "line count past limit")
  `ASSERT_NEXT(a_emit_clears, emit, out_valid_r && cnt_r == '0 && kwlen_r == '0,
               "line end did not post result and clear")
  `ASSERT_NOW(a_stop_zero,
              out_valid_r && (kind_r == dcld_pkg::CMD_HALT || kind_r == dcld_pkg::CMD_UNK),
              left_r == '0 && right_r == '0, "stop or unknown with nonzero velocity")
  `ASSERT_NOW(a_fwd_kind, out_valid_r && fwd_r,
              kind_r == dcld_pkg::CMD_FWD || kind_r == dcld_pkg::CMD_BWD ||
              kind_r == dcld_pkg::CMD_TL || kind_r == dcld_pkg::CMD_TR,
              "forward flag on non-moving command")

endmodule

// File: verif/tb_drive_command_line_decoder_unit.sv
// Testbench for drive_command_line_decoder_unit: streams command-line bytes,
// predicts each decoded drive command and checks it against the result port.
// Depends on dcld_pkg and the RTL of the unit.
module tb_drive_command_line_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 960;
  localparam int IDLE_LIMIT   = 4000;

  typedef struct {
    dcld_pkg::cmd_t      kind;
    logic signed [16:0]  left_vel;
    logic signed [16:0]  right_vel;
    logic                fwd;
  } drive_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_command_kind;
  logic signed [16:0] out_left_vel;
  logic signed [16:0] out_right_vel;
  logic               out_moving_forward;

  logic [7:0]  rx_pending[$];
  drive_cmd_t  cmd_expected[$];
  logic        in_taken = 1'b0;
  int          tx_gap = 0;
  bit          tx_burst = 1'b0;
  int          rx_stall = 0;
  bit          rx_burst = 1'b0;
  int          errors = 0;
  int          idle_cycles = 0;

  // line parser shadow state
  logic [dcld_pkg::LC_W-1:0] ln_len;
  dcld_pkg::phase_t          ln_phase;
  logic [31:0]               ln_kw;
  logic [dcld_pkg::KL_W-1:0] ln_kw_len;
  int                        ln_acc;
  bit                        ln_neg;
  int                        ln_speed;
  int                        ln_turn;

  drive_command_line_decoder_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command_kind  (out_command_kind),
    .out_left_vel      (out_left_vel),
    .out_right_vel     (out_right_vel),
    .out_moving_forward(out_moving_forward)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_line();
    ln_len = '0;
    ln_phase = dcld_pkg::PH_PRE_KW;
    ln_kw = '0;
    ln_kw_len = '0;
    ln_acc = 0;
    ln_neg = 1'b0;
    ln_speed = 0;
    ln_turn = 0;
  endtask

  function automatic int pop_number();
    int mag;
    mag = ln_acc;
    ln_acc = 0;
    if (ln_neg) begin
      ln_neg = 1'b0;
      return -mag;
    end
    return mag;
  endfunction

  task automatic add_digit(input int d);
    int n;
    n = ln_acc * 10 + d;
    ln_acc = (n > int'(dcld_pkg::NUM_LIMIT)) ? int'(dcld_pkg::NUM_LIMIT) : n;
  endtask

  task automatic parse_char(input logic [7:0] c);
    bit ws;
    bit dig;
    bit sgn;
    ws  = (c == dcld_pkg::CH_SP) || (c == dcld_pkg::CH_TAB) ||
          (c == dcld_pkg::CH_VT) || (c == dcld_pkg::CH_FF);
    dig = (c >= dcld_pkg::CH_ZERO) && (c <= dcld_pkg::CH_NINE);
    sgn = (c == dcld_pkg::CH_PLUS) || (c == dcld_pkg::CH_MINUS);
    if (c == dcld_pkg::CH_NUL) begin
      if (ln_phase == dcld_pkg::PH_SPD_SIGN || ln_phase == dcld_pkg::PH_SPD_DIG)
        ln_speed = pop_number();
      else if (ln_phase == dcld_pkg::PH_TRN) ln_turn = pop_number();
      ln_phase = dcld_pkg::PH_DONE;
      return;
    end
    if (ln_phase == dcld_pkg::PH_PRE_KW) begin
      if (ws) return;
      ln_phase = dcld_pkg::PH_KW;
    end
    if (ln_phase == dcld_pkg::PH_KW) begin
      if (ws) begin
        ln_phase = dcld_pkg::PH_PRE_SPD;
        return;
      end
      if (ln_kw_len < dcld_pkg::KEYWORD_CHARS) begin
        if (ln_kw_len < 4) ln_kw = {ln_kw[23:0], c};
        ln_kw_len = ln_kw_len + 1'b1;
        return;
      end
      ln_phase = dcld_pkg::PH_PRE_SPD;
    end
    if (ln_phase == dcld_pkg::PH_PRE_SPD) begin
      if (ws) return;
      if (sgn) begin
        ln_neg = (c == dcld_pkg::CH_MINUS);
        ln_phase = dcld_pkg::PH_SPD_SIGN;
      end else if (dig) begin
        ln_acc = int'(c - dcld_pkg::CH_ZERO);
        ln_phase = dcld_pkg::PH_SPD_DIG;
      end else begin
        ln_phase = dcld_pkg::PH_DONE;
      end
      return;
    end
    if (ln_phase == dcld_pkg::PH_SPD_SIGN) begin
      if (dig) begin
        ln_acc = int'(c - dcld_pkg::CH_ZERO);
        ln_phase = dcld_pkg::PH_SPD_DIG;
      end else begin
        ln_neg = 1'b0;
        ln_phase = dcld_pkg::PH_DONE;
      end
      return;
    end
    if (ln_phase == dcld_pkg::PH_SPD_DIG) begin
      if (dig) begin
        add_digit(int'(c - dcld_pkg::CH_ZERO));
        return;
      end
      ln_speed = pop_number();
      ln_phase = dcld_pkg::PH_PRE_TRN;
      if (ws) return;
    end
    if (ln_phase == dcld_pkg::PH_PRE_TRN) begin
      if (ws) return;
      if (sgn) begin
        ln_neg = (c == dcld_pkg::CH_MINUS);
        ln_phase = dcld_pkg::PH_TRN;
      end else if (dig) begin
        ln_acc = int'(c - dcld_pkg::CH_ZERO);
        ln_phase = dcld_pkg::PH_TRN;
      end else begin
        ln_phase = dcld_pkg::PH_DONE;
      end
      return;
    end
    if (ln_phase == dcld_pkg::PH_TRN) begin
      if (dig) begin
        add_digit(int'(c - dcld_pkg::CH_ZERO));
        return;
      end
      ln_turn = pop_number();
      ln_phase = dcld_pkg::PH_DONE;
    end
  endtask

  task automatic decode_byte(input logic [7:0] c);
    drive_cmd_t cmd;
    int l;
    int r;
    if (c == dcld_pkg::CH_CR || c == dcld_pkg::CH_LF) begin
      if (ln_len == 0) return;
      if (ln_phase == dcld_pkg::PH_SPD_DIG) ln_speed = pop_number();
      else if (ln_phase == dcld_pkg::PH_TRN) ln_turn = pop_number();
      cmd.kind = dcld_pkg::CMD_UNK;
      l = 0;
      r = 0;
      if (ln_kw_len == 3 && ln_kw == dcld_pkg::KW_FWD) begin
        cmd.kind = dcld_pkg::CMD_FWD;
        l = ln_speed;
        r = ln_speed;
      end else if (ln_kw_len == 3 && ln_kw == dcld_pkg::KW_BWD) begin
        cmd.kind = dcld_pkg::CMD_BWD;
        l = -ln_speed;
        r = -ln_speed;
      end else if (ln_kw_len == 2 && ln_kw == dcld_pkg::KW_TL) begin
        cmd.kind = dcld_pkg::CMD_TL;
        l = ln_speed + ln_turn;
        r = ln_speed - ln_turn;
      end else if (ln_kw_len == 2 && ln_kw == dcld_pkg::KW_TR) begin
        cmd.kind = dcld_pkg::CMD_TR;
        l = ln_speed - ln_turn;
        r = ln_speed + ln_turn;
      end else if (ln_kw_len == 4 && ln_kw == dcld_pkg::KW_STOP) begin
        cmd.kind = dcld_pkg::CMD_HALT;
      end
      cmd.left_vel = l[16:0];
      cmd.right_vel = r[16:0];
      cmd.fwd = (l > 0) && (r > 0);
      cmd_expected.push_back(cmd);
      clear_line();
      return;
    end
    if (ln_len >= dcld_pkg::LINE_CHARS) return;
    ln_len = ln_len + 1'b1;
    parse_char(c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_pending.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 5))
      0: return dcld_pkg::CH_TAB;
      1: return dcld_pkg::CH_VT;
      2: return dcld_pkg::CH_FF;
      default: return dcld_pkg::CH_SP;
    endcase
  endfunction

  task automatic push_number();
    int nd;
    if ($urandom_range(0, 3) == 0)
      rx_pending.push_back($urandom_range(0, 1) ? dcld_pkg::CH_MINUS : dcld_pkg::CH_PLUS);
    nd = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
    for (int i = 0; i < nd; i++)
      rx_pending.push_back(8'(dcld_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic push_random_line();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) rx_pending.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 11) begin
      n = $urandom_range(60, 75);
      for (int i = 0; i < n; i++) rx_pending.push_back(8'($urandom_range(8'h21, 8'h7E)));
    end else if (sel >= 14) begin
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) rx_pending.push_back(rand_ws());
      case ($urandom_range(0, 5))
        0: push_text("FWD");
        1: push_text("BWD");
        2: push_text("TL");
        3: push_text("TR");
        4: push_text("STOP");
        default: begin
          n = $urandom_range(1, 20);
          for (int i = 0; i < n; i++) rx_pending.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
      endcase
      for (int k = 0; k < 2; k++) begin
        if ($urandom_range(0, 4) != 0) begin
          n = (k == 1 && $urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2);
          for (int i = 0; i < n; i++) rx_pending.push_back(rand_ws());
          if ($urandom_range(0, 15) == 0)
            rx_pending.push_back(8'($urandom_range(8'h21, 8'h7E)));
          push_number();
        end
      end
      if ($urandom_range(0, 29) == 0) rx_pending.push_back(dcld_pkg::CH_NUL);
      if ($urandom_range(0, 9) == 0) rx_pending.push_back(rand_ws());
    end
    rx_pending.push_back($urandom_range(0, 1) ? dcld_pkg::CH_CR : dcld_pkg::CH_LF);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if ($urandom_range(0, 150) == 0) tx_burst <= !tx_burst;
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (rx_pending.size() > 0) begin
        in_rx_byte <= rx_pending.pop_front();
        in_valid <= 1'b1;
        tx_gap <= tx_burst ? 0 : rand_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if ($urandom_range(0, 150) == 0) rx_burst <= !rx_burst;
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rx_burst && $urandom_range(0, 3) == 0) rx_stall <= rand_gap();
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    drive_cmd_t exp_cmd;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (cmd_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual command_kind %0d",
                   $time, out_command_kind);
          errors++;
        end else begin
          exp_cmd = cmd_expected.pop_front();
          if (out_command_kind !== exp_cmd.kind) begin
            $display("%0t: command_kind expected %0d actual %0d",
                     $time, exp_cmd.kind, out_command_kind);
            errors++;
          end
          if (out_left_vel !== exp_cmd.left_vel) begin
            $display("%0t: left_vel expected %0d actual %0d",
                     $time, exp_cmd.left_vel, out_left_vel);
            errors++;
          end
          if (out_right_vel !== exp_cmd.right_vel) begin
            $display("%0t: right_vel expected %0d actual %0d",
                     $time, exp_cmd.right_vel, out_right_vel);
            errors++;
          end
          if (out_moving_forward !== exp_cmd.fwd) begin
            $display("%0t: moving_forward expected %0d actual %0d",
                     $time, exp_cmd.fwd, out_moving_forward);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) decode_byte(in_rx_byte);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress, %0d results outstanding", $time, cmd_expected.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    clear_line();
    push_text("FWD 100 0\n");
    push_text("BWD -7\r");
    push_text("TL 99999 -12\n");
    push_text("TR +5 3\n");
    push_text("STOP\n");
    push_text("\n\r");
    rx_pending.push_back(dcld_pkg::CH_SP);
    rx_pending.push_back(dcld_pkg::CH_TAB);
    rx_pending.push_back(dcld_pkg::CH_VT);
    rx_pending.push_back(dcld_pkg::CH_FF);
    rx_pending.push_back(dcld_pkg::CH_LF);
    rx_pending.push_back(dcld_pkg::CH_NUL);
    push_text("FWD 3\n");
    push_text("TL 4");
    rx_pending.push_back(dcld_pkg::CH_NUL);
    push_text(" 9\n");
    push_text("FWD -x 5\n");
    push_text("TR 12-5\n");
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(8'h80);
    rx_pending.push_back(dcld_pkg::CH_CR);
    for (int i = 0; i < RANDOM_BYTES;) begin
      int before_sz;
      before_sz = rx_pending.size();
      push_random_line();
      i += rx_pending.size() - before_sz;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rx_pending.size() != 0 || in_valid) @(posedge clk);
    while (cmd_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/dcld_pkg.sv
hdl/drive_command_line_decoder_unit.sv
verif/tb_drive_command_line_decoder_unit.sv
